>>> rtl/bounded_array_list_unit_macros.svh
// Assertion macros shared by the checker of the bounded array list unit.
`ifndef BOUNDED_ARRAY_LIST_UNIT_MACROS_SVH
`define BOUNDED_ARRAY_LIST_UNIT_MACROS_SVH

// Check a property on every rising edge, muted while reset is high.
`define BAL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset cycles included.
`define BAL_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/bal_pkg.sv
// Package: codes, widths and controller/datapath interface types of the list unit.
`default_nettype none

package bal_pkg;

   localparam int CAPACITY_DEFAULT = 256;

   localparam int TYPE_W = 3;
   localparam int DATA_W = 32;
   localparam int POS_W  = 9;
   localparam int STAT_W = 2;

   // request codes
   localparam logic [TYPE_W-1:0] REQ_APPEND    = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_REM_END   = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_INS_FRONT = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_REM_FRONT = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_INS_AT    = 3'd4;
   localparam logic [TYPE_W-1:0] REQ_REM_AT    = 3'd5;
   localparam logic [TYPE_W-1:0] REQ_READ_AT   = 3'd6;
   localparam logic [TYPE_W-1:0] REQ_NONE      = 3'd7;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

   // commands from controller to datapath
   typedef struct packed {
      logic load;        // latch the accepted transaction
      logic check;       // latch the status, clear the data
      logic start;       // set up cursor, target and limit
      logic shift_up;    // move one entry up (insert)
      logic shift_down;  // move one entry down (remove or read)
      logic place;       // write the new element, bump the count
      logic retire;      // drop the count after a removal
      logic finish;      // load the result register
   } bal_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic is_ins;
      logic is_rd;
      logic is_nop;
      logic err;
      logic up_done;
      logic down_done;
   } bal_sts_type;

endpackage

`default_nettype wire

>>> rtl/bal_ctrl.sv
// Controller: sequences one transaction at a time through check, shift and reply.
`default_nettype none

module bal_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   input  wire bal_pkg::bal_sts_type sts,
   output bal_pkg::bal_cmd_type cmd
);
   import bal_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_INS   = 3'd2;
   localparam logic [2:0] S_REM   = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            if (sts.err || sts.is_nop) begin
               state_in = S_DONE;
            end else begin
               cmd.start = 1'b1;
               state_in  = sts.is_ins ? S_INS : S_REM;
            end
         end
         S_INS: begin
            if (sts.up_done) begin
               cmd.place = 1'b1;
               state_in  = S_DONE;
            end else begin
               cmd.shift_up = 1'b1;
            end
         end
         S_REM: begin
            if (sts.down_done) begin
               cmd.retire = !sts.is_rd;
               state_in   = S_DONE;
            end else begin
               cmd.shift_down = 1'b1;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> rtl/bal_dp.sv
// Datapath: element store, count, shift cursor and result register of the list unit.
`default_nettype none

module bal_dp #(
   parameter int CAPACITY = bal_pkg::CAPACITY_DEFAULT
) (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire bal_pkg::bal_cmd_type               cmd,
   output bal_pkg::bal_sts_type                    sts,
   input  wire        [bal_pkg::TYPE_W-1:0]        req_type,
   input  wire signed [bal_pkg::DATA_W-1:0]        req_value,
   input  wire        [bal_pkg::POS_W-1:0]         req_position,
   output logic signed [bal_pkg::DATA_W-1:0]       rsp_data_out,
   output logic       [bal_pkg::POS_W-1:0]         rsp_count_after,
   output logic       [bal_pkg::STAT_W-1:0]        rsp_status
);
   import bal_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int WW = (CW > POS_W) ? CW : POS_W;

   logic signed [DATA_W-1:0] mem [CAPACITY];

   logic [TYPE_W-1:0]        type_ff, type_in;
   logic signed [DATA_W-1:0] value_ff, value_in;
   logic [POS_W-1:0]         pos_ff, pos_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [CW-1:0]            where_ff, where_in;
   logic [CW-1:0]            limit_ff, limit_in;
   logic [CW-1:0]            cursor_ff, cursor_in;
   logic                     pend_ff, pend_in;
   logic                     pend_first_ff, pend_first_in;
   logic [AW-1:0]            pend_addr_ff, pend_addr_in;
   logic signed [DATA_W-1:0] rd_data_ff;
   logic signed [DATA_W-1:0] data_ff, data_in;
   logic [STAT_W-1:0]        status_ff, status_in;
   logic signed [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [POS_W-1:0]         rsp_count_ff, rsp_count_in;
   logic [STAT_W-1:0]        rsp_status_ff, rsp_status_in;

   logic              is_ins, is_rem, is_rd;
   logic [WW-1:0]     count_w, pos_w, where_w;
   logic [CW-1:0]     where_c, cursor_m1;
   logic [STAT_W-1:0] status_c;
   logic              rd_issue;
   logic [AW-1:0]     rd_addr;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic signed [DATA_W-1:0] wr_data;

   assign is_ins = type_ff inside {REQ_APPEND, REQ_INS_FRONT, REQ_INS_AT};
   assign is_rem = type_ff inside {REQ_REM_END, REQ_REM_FRONT, REQ_REM_AT};
   assign is_rd  = (type_ff == REQ_READ_AT);

   assign count_w = WW'(count_ff);
   assign pos_w   = WW'(pos_ff);

   always_comb begin
      case (type_ff)
         REQ_APPEND:                   where_w = count_w;
         REQ_INS_FRONT, REQ_REM_FRONT: where_w = '0;
         REQ_REM_END:                  where_w = count_w - WW'(1);
         default:                      where_w = pos_w;
      endcase
   end
   assign where_c = where_w[CW-1:0];

   always_comb begin
      status_c = ST_OK;
      if (is_ins) begin
         if (count_w >= WW'(CAPACITY)) begin
            status_c = ST_FULL;
         end else if (where_w > count_w) begin
            status_c = ST_RANGE;
         end
      end else if (is_rem || is_rd) begin
         if (count_w == '0) begin
            status_c = ST_EMPTY;
         end else if (where_w >= count_w) begin
            status_c = ST_RANGE;
         end
      end
   end

   // one read and one write of the store per cycle
   assign cursor_m1 = cursor_ff - CW'(1);
   assign rd_issue  = (cmd.shift_up && (cursor_ff != where_ff)) ||
                      (cmd.shift_down && (cursor_ff != limit_ff));
   assign rd_addr   = is_ins ? cursor_m1[AW-1:0] : cursor_ff[AW-1:0];
   assign wr_en     = (pend_ff && !pend_first_ff) || cmd.place;
   assign wr_addr   = cmd.place ? where_ff[AW-1:0] : pend_addr_ff;
   assign wr_data   = cmd.place ? value_ff : rd_data_ff;

   always_comb begin
      type_in       = type_ff;
      value_in      = value_ff;
      pos_in        = pos_ff;
      count_in      = count_ff;
      where_in      = where_ff;
      limit_in      = limit_ff;
      cursor_in     = cursor_ff;
      pend_in       = rd_issue;
      pend_first_in = !is_ins && (cursor_ff == where_ff);
      pend_addr_in  = is_ins ? cursor_ff[AW-1:0] : cursor_m1[AW-1:0];
      data_in       = data_ff;
      status_in     = status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;

      if (cmd.load) begin
         type_in  = req_type;
         value_in = req_value;
         pos_in   = req_position;
      end
      if (cmd.check) begin
         status_in = status_c;
         data_in   = '0;
      end
      if (cmd.start) begin
         where_in  = where_c;
         cursor_in = is_ins ? count_ff : where_c;
         limit_in  = is_rd ? (where_c + CW'(1)) : count_ff;
      end
      if (rd_issue) begin
         cursor_in = cmd.shift_up ? cursor_m1 : (cursor_ff + CW'(1));
      end
      if (pend_ff && pend_first_ff) begin
         data_in = rd_data_ff;
      end
      if (cmd.place) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.retire) begin
         count_in = count_ff - CW'(1);
      end
      if (cmd.finish) begin
         rsp_data_in   = data_ff;
         rsp_count_in  = count_w[POS_W-1:0];
         rsp_status_in = status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_issue) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff       <= type_in;
      value_ff      <= value_in;
      pos_ff        <= pos_in;
      where_ff      <= where_in;
      limit_ff      <= limit_in;
      cursor_ff     <= cursor_in;
      pend_first_ff <= pend_first_in;
      pend_addr_ff  <= pend_addr_in;
      data_ff       <= data_in;
      status_ff     <= status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign sts.is_ins    = is_ins;
   assign sts.is_rd     = is_rd;
   assign sts.is_nop    = (type_ff == REQ_NONE);
   assign sts.err       = (status_c != ST_OK);
   assign sts.up_done   = (cursor_ff == where_ff) && !pend_ff;
   assign sts.down_done = (cursor_ff == limit_ff) && !pend_ff;

   assign rsp_data_out    = rsp_data_ff;
   assign rsp_count_after = rsp_count_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

`default_nettype wire

>>> rtl/bounded_array_list_unit.sv
// Top level of the bounded array list unit: controller plus datapath.
`default_nettype none

// An ordered list of signed 32-bit elements held in a single store of
// CAPACITY entries, with a count that resets to zero. Each transaction on
// the req_ channel appends, removes from the end, inserts or removes at the
// front, inserts or removes at a position, or reads at a position; exactly
// one transaction comes back on the rsp_ channel with the removed or read
// element (zero otherwise), the count after the request (low nine bits) and
// a status of ok, full, empty or bad position, the list being left
// untouched on any error. Work is one transaction at a time: req_stall
// rises the cycle after an accept and falls once the result has gone into
// the output register, which may still be waiting for rsp_stall to drop
// when the next transaction is taken. Inserts and removals move one list
// entry per clock through the store's single read and single write port.
// A transaction on an error or the unused code goes straight from the
// check to the reply; an insert or removal lasts longer the more entries
// it moves, the longest being a removal at the front of a full list, and
// a result still held by rsp_stall adds its wait. The store is not
// cleared after reset; only entries below the count are ever read.
module bounded_array_list_unit #(
   parameter int CAPACITY = bal_pkg::CAPACITY_DEFAULT
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_stall,
   input  wire        [bal_pkg::TYPE_W-1:0]   req_type,
   input  wire signed [bal_pkg::DATA_W-1:0]   req_value,
   input  wire        [bal_pkg::POS_W-1:0]    req_position,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output logic signed [bal_pkg::DATA_W-1:0]  rsp_data_out,
   output logic       [bal_pkg::POS_W-1:0]    rsp_count_after,
   output logic       [bal_pkg::STAT_W-1:0]   rsp_status
);
   import bal_pkg::*;

   // command and status links between the two halves
   bal_cmd_type cmd;
   bal_sts_type sts;

   // Controller: accept, check, shift until done, then hand the result to
   // the output register once it is free.
   bal_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath: hold the transaction, the count and the store; advance the
   // shift cursor and drop the result into the output register on command.
   bal_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_type        (req_type),
      .req_value       (req_value),
      .req_position    (req_position),
      .rsp_data_out    (rsp_data_out),
      .rsp_count_after (rsp_count_after),
      .rsp_status      (rsp_status)
   );

endmodule

`default_nettype wire

>>> rtl/bal_checker.sv
// Port-level checker of the bounded array list unit and its bind.
`default_nettype none

`include "bounded_array_list_unit_macros.svh"

module bal_checker #(
   parameter int CAPACITY = bal_pkg::CAPACITY_DEFAULT
) (
   input wire                               clock,
   input wire                               reset,
   input wire                               req_valid,
   input wire                               req_stall,
   input wire                               rsp_valid,
   input wire                               rsp_stall,
   input wire signed [bal_pkg::DATA_W-1:0]  rsp_data_out,
   input wire        [bal_pkg::POS_W-1:0]   rsp_count_after,
   input wire        [bal_pkg::STAT_W-1:0]  rsp_status
);
   import bal_pkg::*;

   localparam logic [POS_W-1:0] CAP_LOW = POS_W'(CAPACITY);
   localparam int RSP_W = 1 + DATA_W + POS_W + STAT_W;

   logic             req_fire;
   logic             rsp_wait;
   logic             rsp_err;
   logic             count_fits;
   logic [RSP_W-1:0] rsp_word;

   assign req_fire   = req_valid && !req_stall;
   assign rsp_wait   = rsp_valid && rsp_stall;
   assign rsp_err    = rsp_valid && (rsp_status != ST_OK);
   assign rsp_word   = {rsp_valid, rsp_data_out, rsp_count_after, rsp_status};
   assign count_fits = ((rsp_status != ST_FULL) || (rsp_count_after == CAP_LOW)) &&
                       ((rsp_status != ST_EMPTY) || (rsp_count_after == '0));

   // hold a stalled result
   `BAL_ASSERT(a_rsp_hold, clock, reset, rsp_wait |=> $stable(rsp_word), "stalled result moved")

   // drop the valid after reset
   `BAL_ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_valid, "result valid after reset")

   // hold off the next transaction while one is in work
   `BAL_ASSERT(a_one_at_a_time, clock, reset, req_fire |=> req_stall, "taken while busy")

   // an error result carries no element
   `BAL_ASSERT(a_err_zero, clock, reset, rsp_err |-> (rsp_data_out == '0), "data with error")

   // full means the count sits at capacity, empty means zero
   `BAL_ASSERT(a_status_count, clock, reset, rsp_valid |-> count_fits, "count against status")

endmodule

bind bounded_array_list_unit bal_checker #(
   .CAPACITY (CAPACITY)
) u_bal_checker (.*);

`default_nettype wire

>>> tb/sv/bal_list_checker.sv
`timescale 1ns / 1ps
// Checker for the bounded array list unit: shadow list, expected results and comparison.
module bal_list_checker #(
   parameter int CAPACITY = bal_pkg::CAPACITY_DEFAULT
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   input  wire                               req_stall,
   input  wire        [bal_pkg::TYPE_W-1:0]  req_type,
   input  wire signed [bal_pkg::DATA_W-1:0]  req_value,
   input  wire        [bal_pkg::POS_W-1:0]   req_position,
   input  wire                               rsp_valid,
   input  wire                               rsp_stall,
   input  wire signed [bal_pkg::DATA_W-1:0]  rsp_data_out,
   input  wire        [bal_pkg::POS_W-1:0]   rsp_count_after,
   input  wire        [bal_pkg::STAT_W-1:0]  rsp_status,
   output int                                mismatch_count,
   output int                                outstanding,
   output int                                list_count
);
   import bal_pkg::*;

   typedef struct {
      logic [DATA_W-1:0] data;
      logic [POS_W-1:0]  count;
      logic [STAT_W-1:0] status;
   } list_result_type;

   logic [DATA_W-1:0] shadow_list [CAPACITY];
   int                held = 0;
   list_result_type   pending_results [$];

   // apply one transaction to the shadow list and return what the unit should answer
   function automatic list_result_type apply_list_request(input logic [TYPE_W-1:0] kind,
                                                          input logic [DATA_W-1:0] value,
                                                          input logic [POS_W-1:0]  pos);
      list_result_type r;
      int              where;
      int              i;
      r.data   = '0;
      r.status = ST_OK;
      case (kind)
         REQ_APPEND, REQ_INS_FRONT, REQ_INS_AT: begin
            where = (kind == REQ_APPEND) ? held : (kind == REQ_INS_FRONT) ? 0 : int'(pos);
            if (held >= CAPACITY) begin
               r.status = ST_FULL;
            end else if (where > held) begin
               r.status = ST_RANGE;
            end else begin
               for (i = held; i > where; i--) shadow_list[i] = shadow_list[i-1];
               shadow_list[where] = value;
               held++;
            end
         end
         REQ_REM_END, REQ_REM_FRONT, REQ_REM_AT, REQ_READ_AT: begin
            where = (kind == REQ_REM_END) ? held - 1 : (kind == REQ_REM_FRONT) ? 0 : int'(pos);
            if (held == 0) begin
               r.status = ST_EMPTY;
            end else if (where >= held) begin
               r.status = ST_RANGE;
            end else if (kind == REQ_READ_AT) begin
               r.data = shadow_list[where];
            end else begin
               r.data = shadow_list[where];
               for (i = where; i + 1 < held; i++) shadow_list[i] = shadow_list[i+1];
               held--;
            end
         end
         default: ;
      endcase
      r.count = held[POS_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin : watch
      list_result_type got;
      list_result_type want;
      if (reset) begin
         held = 0;
         pending_results.delete();
      end else begin
         // compare first: a result never belongs to a transaction taken at the same edge
         if (rsp_valid && !rsp_stall) begin
            got.data   = rsp_data_out;
            got.count  = rsp_count_after;
            got.status = rsp_status;
            if (pending_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected result data %0d count %0d status %0d", $realtime,
                           $signed(got.data), got.count, got.status);
            end else begin
               want = pending_results.pop_front();
               if (got.data !== want.data || got.count !== want.count ||
                   got.status !== want.status) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: result mismatch data exp %0d got %0d, %s, %s",
                              $realtime, $signed(want.data), $signed(got.data),
                              $sformatf("count exp %0d got %0d", want.count, got.count),
                              $sformatf("status exp %0d got %0d", want.status,
                                        got.status));
               end
            end
         end
         if (req_valid && !req_stall)
            pending_results.push_back(apply_list_request(req_type, req_value, req_position));
      end
      outstanding <= pending_results.size();
      list_count  <= held;
   end

endmodule

>>> tb/sv/tb_bounded_array_list_unit.sv
`timescale 1ns / 1ps
// Testbench top for the bounded array list unit: clock, reset, stimulus and verdict.
module tb_bounded_array_list_unit;
   import bal_pkg::*;

   localparam int CAPACITY    = CAPACITY_DEFAULT;
   localparam int HOLD_CYCLES = 300;   // long receiver hold-off, enough to back up the unit

   logic                     clock        = 1'b0;
   logic                     reset        = 1'b1;
   logic                     req_valid    = 1'b0;
   logic [TYPE_W-1:0]        req_type     = REQ_NONE;
   logic signed [DATA_W-1:0] req_value    = '0;
   logic [POS_W-1:0]         req_position = '0;
   logic                     rsp_stall    = 1'b0;

   wire                      req_stall;
   wire                      rsp_valid;
   wire signed [DATA_W-1:0]  rsp_data_out;
   wire [POS_W-1:0]          rsp_count_after;
   wire [STAT_W-1:0]         rsp_status;

   int mismatch_count;
   int outstanding;
   int list_count;

   // the sender bumps hold_asks, the receiver keeps its own tally of holds served
   int hold_asks   = 0;
   int holds_done  = 0;
   int burst_left  = 0;

   always #2 clock = ~clock;

   bounded_array_list_unit #(.CAPACITY(CAPACITY)) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_value       (req_value),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data_out    (rsp_data_out),
      .rsp_count_after (rsp_count_after),
      .rsp_status      (rsp_status)
   );

   bal_list_checker #(.CAPACITY(CAPACITY)) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_value       (req_value),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data_out    (rsp_data_out),
      .rsp_count_after (rsp_count_after),
      .rsp_status      (rsp_status),
      .mismatch_count  (mismatch_count),
      .outstanding     (outstanding),
      .list_count      (list_count)
   );

   // Offer one transaction from a falling edge and hold it until accepted.
   // Returns on the falling edge after the accept with valid still high, so a
   // following call re-drives valid without ever dropping it in between.
   task automatic send_request(input logic [TYPE_W-1:0] kind,
                               input logic signed [DATA_W-1:0] value,
                               input logic [POS_W-1:0] pos);
      req_valid    <= 1'b1;
      req_type     <= kind;
      req_value    <= value;
      req_position <= pos;
      do @(posedge clock); while (req_stall !== 1'b0);
      @(negedge clock);
   endtask

   // Drop valid for a number of cycles (at least one).
   task automatic idle_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // Drop valid and hold until every expected result has come back.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Work in bursts: when a burst runs out, maybe rest, then start a fresh one.
   task automatic pace_sender();
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 9));
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
   endtask

   // Pick one transaction steered by the predicted list size: insert_pct sets the share
   // of well-formed inserts, most of the rest are well-formed removals and reads, and a
   // small tail is noise with any code and any position.
   task automatic send_random_item(input int insert_pct);
      int                       pick;
      logic [TYPE_W-1:0]        kind;
      logic [POS_W-1:0]         pos;
      logic signed [DATA_W-1:0] value;
      pick  = $urandom_range(0, 99);
      value = $urandom;
      pos   = POS_W'($urandom);
      if (pick < insert_pct) begin
         case ($urandom_range(0, 2))
            0:       kind = REQ_APPEND;
            1:       kind = REQ_INS_FRONT;
            default: kind = REQ_INS_AT;
         endcase
         if (kind == REQ_INS_AT) pos = POS_W'($urandom_range(0, list_count));
      end else if (pick < 94) begin
         case ($urandom_range(0, 3))
            0:       kind = REQ_REM_END;
            1:       kind = REQ_REM_FRONT;
            2:       kind = REQ_REM_AT;
            default: kind = REQ_READ_AT;
         endcase
         if (list_count > 0) pos = POS_W'($urandom_range(0, list_count - 1));
      end else begin
         kind = TYPE_W'($urandom_range(0, 7));
      end
      pace_sender();
      send_request(kind, value, pos);
   endtask

   // Receiver: switch between stall patterns of its own, and serve long hold-offs
   // when the sender asks for one.
   initial begin : receiver
      int   mode;
      int   span;
      int   hold_count;
      logic take_hold;
      mode = 0;
      span = 0;
      forever begin
         @(posedge clock);
         take_hold = (hold_asks != holds_done);
         @(negedge clock);
         if (take_hold) begin
            holds_done++;
            rsp_stall <= 1'b1;
            for (hold_count = 1; hold_count < HOLD_CYCLES; hold_count++) @(negedge clock);
         end else begin
            if (span == 0) begin
               mode = $urandom_range(0, 3);
               span = $urandom_range(10, 120);
            end
            span--;
            case (mode)
               0:       rsp_stall <= 1'b0;                          // stretch with no stalls
               1:       rsp_stall <= ($urandom_range(0, 1) == 1);
               2:       rsp_stall <= ($urandom_range(0, 3) != 0);   // mostly stalled
               default: rsp_stall <= ((span % 5) < 2);              // fixed rhythm
            endcase
         end
      end
   end

   // Stimulus and verdict.
   initial begin : stimulus
      int n;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty-list removals and reads, bad positions, the unused code,
      // value extremes, insert at the count, then walk back down to empty.
      send_request(REQ_REM_END,   32'sd0,          9'd0);
      send_request(REQ_REM_FRONT, 32'sd0,          9'd0);
      send_request(REQ_REM_AT,    32'sd0,          9'd0);
      send_request(REQ_READ_AT,   32'sd0,          9'd0);
      send_request(REQ_INS_AT,    32'sd5,          9'd1);
      send_request(REQ_NONE,      -32'sd1,         9'd511);
      send_request(REQ_APPEND,    32'sh8000_0000,  9'd0);
      send_request(REQ_INS_FRONT, 32'sh7fff_ffff,  9'd511);
      send_request(REQ_INS_AT,    -32'sd1,         9'd2);
      send_request(REQ_INS_AT,    32'sd0,          9'd1);
      send_request(REQ_READ_AT,   32'sd0,          9'd0);
      send_request(REQ_READ_AT,   32'sd0,          9'd1);
      send_request(REQ_READ_AT,   32'sd0,          9'd2);
      send_request(REQ_READ_AT,   32'sd0,          9'd3);
      send_request(REQ_READ_AT,   32'sd0,          9'd4);
      send_request(REQ_READ_AT,   32'sd0,          9'd511);
      send_request(REQ_REM_AT,    32'sd0,          9'd256);
      send_request(REQ_INS_AT,    32'sd7,          9'd511);
      send_request(REQ_REM_AT,    32'sd0,          9'd1);
      send_request(REQ_REM_END,   32'sd0,          9'd0);
      send_request(REQ_REM_FRONT, 32'sd0,          9'd0);
      send_request(REQ_REM_AT,    32'sd0,          9'd0);
      send_request(REQ_READ_AT,   32'sd0,          9'd0);
      wait_for_drain();

      // Fill the list to capacity with mostly inserts. Early on, ask for a long
      // receiver hold-off and keep offering transactions straight through it so
      // the output register and the unit both back up and req_stall holds.
      n = 0;
      while (list_count < CAPACITY) begin
         if (n == 40) begin
            hold_asks++;
            repeat (12) send_request(REQ_APPEND, $urandom, 9'd0);
         end
         send_random_item(88);
         n++;
      end

      // Full list: every insert kind must bounce, then probe the top end.
      send_request(REQ_APPEND,    $urandom, 9'd0);
      send_request(REQ_INS_FRONT, $urandom, 9'd0);
      send_request(REQ_INS_AT,    $urandom, 9'd256);
      send_request(REQ_READ_AT,   32'sd0,   9'd255);
      send_request(REQ_READ_AT,   32'sd0,   9'd256);
      send_request(REQ_REM_AT,    32'sd0,   9'd255);
      send_request(REQ_INS_AT,    $urandom, 9'd255);
      wait_for_drain();

      // Drain part-way with mostly removals and reads.
      repeat (90) send_random_item(30);

      // Everything offered: drain, allow for the unit's longest transaction, decide.
      wait_for_drain();
      repeat (CAPACITY + 8) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0)
         $display("tb_bounded_array_list_unit: clean");
      else
         $display("tb_bounded_array_list_unit: errors");
      $finish;
   end

   // Backstop against a hung handshake: far beyond the slowest legal run.
   initial begin : watchdog
      #4_000_000;
      $display("tb_bounded_array_list_unit: errors");
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl
rtl/bal_pkg.sv
rtl/bal_ctrl.sv
rtl/bal_dp.sv
rtl/bounded_array_list_unit.sv
rtl/bal_checker.sv
tb/sv/bal_list_checker.sv
tb/sv/tb_bounded_array_list_unit.sv
